### sv/ipd_pkg.sv
// Shared constants and types for the interpolated peak detector.
`timescale 1ns / 1ps
`default_nettype none

package ipd_pkg;

    localparam int TAPS     = 8;
    localparam int SAMPLE_W = 16;
    localparam int PEAK_W   = 16;
    localparam int FILL_W   = $clog2(TAPS + 1);
    // Accumulator: 17-bit pair sums times 16-bit coefficients, four terms
    localparam int ACC_W    = 34;

    // Half-sample interpolation filter, Q0.16 magnitudes, center taps first
    localparam logic [15:0] COEF0 = 16'd39127;
    localparam logic [15:0] COEF1 = 16'd7706;
    localparam logic [15:0] COEF2 = 16'd1497;
    localparam logic [15:0] COEF3 = 16'd149;

    // Rounding offset: one half in Q16
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t [TAPS-1:0]         hist_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic [FILL_W-1:0]          fill_t;

endpackage

`default_nettype wire

### sv/ipd_interp.sv
// Symmetric 8-tap half-sample interpolator with rounded magnitude output.
`timescale 1ns / 1ps
`default_nettype none

module ipd_interp
    import ipd_pkg::*;
(
    input  hist_t             history,
    output logic [PEAK_W-1:0] mag
);

    logic signed [SAMPLE_W:0] pair0;
    logic signed [SAMPLE_W:0] pair1;
    logic signed [SAMPLE_W:0] pair2;
    logic signed [SAMPLE_W:0] pair3;
    acc_t                     prod0;
    acc_t                     prod1;
    acc_t                     prod2;
    acc_t                     prod3;
    acc_t                     acc;
    logic [ACC_W-1:0]         acc_abs;
    logic [ACC_W-1:0]         rounded;

    // Fold symmetric taps, oldest sample at index 0
    assign pair0 = (SAMPLE_W+1)'(history[3]) + (SAMPLE_W+1)'(history[4]);
    assign pair1 = (SAMPLE_W+1)'(history[2]) + (SAMPLE_W+1)'(history[5]);
    assign pair2 = (SAMPLE_W+1)'(history[1]) + (SAMPLE_W+1)'(history[6]);
    assign pair3 = (SAMPLE_W+1)'(history[0]) + (SAMPLE_W+1)'(history[7]);

    // Constant multiplies, coefficients zero-extended as positive values
    assign prod0 = acc_t'(pair0) * acc_t'({1'b0, COEF0});
    assign prod1 = acc_t'(pair1) * acc_t'({1'b0, COEF1});
    assign prod2 = acc_t'(pair2) * acc_t'({1'b0, COEF2});
    assign prod3 = acc_t'(pair3) * acc_t'({1'b0, COEF3});

    // Alternating-sign sum
    assign acc = prod0 - prod1 + prod2 - prod3;

    // Magnitude, rounded half up on the magnitude; result fits in 16 bits
    assign acc_abs = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    assign rounded = acc_abs + ROUND_HALF;
    assign mag     = rounded[PEAK_W+15:16];

endmodule

`default_nettype wire

### sv/interpolated_peak_detector_unit.sv
// Top level of the interpolated peak detector.
//
// Input channel: sample, block_end with sample_valid / sample_stall.
// Output channel: peak, window_seen with result_valid / result_stall.
// One sample item is taken per cycle while sample_stall is low. Each item
// shifts an 8-deep history; once eight samples of the current block are
// held, the item completes a window whose half-sample interpolated
// magnitude updates a running peak. An item with block_end set produces
// one result item; others produce none. The closing item lands in the
// history register, then the result register is loaded from the filter.
// Throughput: one item a cycle while sample_stall is low, set by the
// single filter stage between history and result registers.
// When the receiver stalls, the held result stays put and items keep
// flowing; the input stalls only when a second block end reaches the
// filter stage while the result register is still full and stalled.
// Reset clears the item valid flag, fill count, running peak and the
// result valid flag; the next block starts from an empty count.
`timescale 1ns / 1ps
`default_nettype none

module interpolated_peak_detector_unit
    import ipd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                sample_valid,
    output logic                     sample_stall,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic                block_end,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic [PEAK_W-1:0]        peak,
    output logic                     window_seen
);

    hist_t               history_reg;
    fill_t               fill_reg;
    fill_t               fill_sat;
    logic                item_valid_reg;
    logic                item_last_reg;
    logic                item_win_reg;
    logic [PEAK_W-1:0]   running_peak_reg;
    logic [PEAK_W-1:0]   running_peak_next;
    logic                result_valid_reg;
    logic [PEAK_W-1:0]   peak_reg;
    logic                window_seen_reg;
    logic [PEAK_W-1:0]   mag;
    logic                out_free;
    logic                blocked;
    logic                accept;
    logic                fire;

    // Handshake control
    assign out_free     = !result_valid_reg || !result_stall;
    assign blocked      = item_valid_reg && item_last_reg && !out_free;
    assign sample_stall = blocked;
    assign accept       = sample_valid && !blocked;
    assign fire         = item_valid_reg && !blocked;

    // Saturating sample count for the block
    assign fill_sat = (fill_reg == fill_t'(TAPS)) ? fill_reg : fill_reg + fill_t'(1);

    // History shift register, newest at the top
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            history_reg <= {sample_t'(sample), history_reg[TAPS-1:1]};
        end
    end

    // Item flags and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            item_valid_reg <= 1'b0;
            item_last_reg  <= 1'b0;
            item_win_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg       <= block_end ? '0 : fill_sat;
                item_valid_reg <= 1'b1;
                item_last_reg  <= block_end;
                item_win_reg   <= (fill_sat == fill_t'(TAPS));
            end
            else if (fire)
            begin
                item_valid_reg <= 1'b0;
            end
        end
    end

    // Interpolation filter
    ipd_interp u_interp (
        .history (history_reg),
        .mag     (mag)
    );

    // Running maximum, replaced only by a strictly larger value
    assign running_peak_next = (item_win_reg && (mag > running_peak_reg)) ?
                               mag : running_peak_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_peak_reg <= '0;
        end
        else if (fire)
        begin
            running_peak_reg <= item_last_reg ? '0 : running_peak_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (fire && item_last_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && item_last_reg)
        begin
            peak_reg        <= running_peak_next;
            window_seen_reg <= item_win_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign peak         = peak_reg;
    assign window_seen  = window_seen_reg;

endmodule

`default_nettype wire

### bench/tb_interpolated_peak_detector_unit.sv
// Testbench for the interpolated peak detector: directed and random sample blocks checked against a local model.
`timescale 1ns / 1ps

module tb_interpolated_peak_detector_unit;
    import ipd_pkg::*;

    // Filter taps, Q0.16 magnitudes, center pair first
    localparam longint TAP_C0 = 39127;
    localparam longint TAP_C1 = 7706;
    localparam longint TAP_C2 = 1497;
    localparam longint TAP_C3 = 149;

    localparam int IDLE_PCT    = 28;
    localparam int SETTLE_CYC  = 6;

    // Sample styles for generated blocks
    typedef enum int {STYLE_FULL, STYLE_QUIET, STYLE_RAILS} sample_style_t;

    typedef struct packed {
        logic [PEAK_W-1:0] peak;
        logic              window_seen;
    } peak_report_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                sample_valid = 1'b0;
    logic                sample_stall;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                block_end = 1'b0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [PEAK_W-1:0]   peak;
    logic                window_seen;

    // Model state
    sample_t           window_hist [TAPS];
    int                window_fill;
    logic [PEAK_W-1:0] block_peak;
    peak_report_t      pending_reports [$];

    int error_count = 0;
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold_cycles = 0;

    interpolated_peak_detector_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .block_end    (block_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .peak         (peak),
        .window_seen  (window_seen)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Half-sample interpolated magnitude of the current window, rounded half up
    function automatic logic [PEAK_W-1:0] interp_magnitude();
        longint acc;
        longint mag;
        acc  = TAP_C0 * (longint'(window_hist[3]) + longint'(window_hist[4]));
        acc -= TAP_C1 * (longint'(window_hist[2]) + longint'(window_hist[5]));
        acc += TAP_C2 * (longint'(window_hist[1]) + longint'(window_hist[6]));
        acc -= TAP_C3 * (longint'(window_hist[0]) + longint'(window_hist[7]));
        mag = (acc < 0) ? -acc : acc;
        return PEAK_W'((mag + 32768) >>> 16);
    endfunction

    task automatic clear_model();
        for (int i = 0; i < TAPS; i++)
            window_hist[i] = '0;
        window_fill = 0;
        block_peak  = '0;
    endtask

    // Shift in one accepted sample and queue the report if it closes a block
    task automatic advance_model(sample_t value, logic last);
        logic [PEAK_W-1:0] mag;
        peak_report_t      report;
        for (int i = 0; i < TAPS - 1; i++)
            window_hist[i] = window_hist[i + 1];
        window_hist[TAPS - 1] = value;
        if (window_fill < TAPS)
            window_fill++;
        if (window_fill >= TAPS)
        begin
            mag = interp_magnitude();
            if (mag > block_peak)
                block_peak = mag;
        end
        if (last)
        begin
            report.peak        = block_peak;
            report.window_seen = (window_fill >= TAPS);
            pending_reports.push_back(report);
            window_fill = 0;
            block_peak  = '0;
        end
    endtask

    // Offer one item and wait until it is taken
    task automatic send_item(sample_t value, logic last);
        @(negedge clk);
        while (tx_idle && $urandom_range(99) < IDLE_PCT)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        block_end    <= last;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        advance_model(value, last);
    endtask

    function automatic sample_t pick_sample(sample_style_t style);
        int r;
        r = $urandom_range(2);
        case (style)
            STYLE_QUIET: return sample_t'(int'($urandom_range(600)) - 300);
            STYLE_RAILS: return (r == 0) ? sample_t'(16'sh7fff) :
                                (r == 1) ? sample_t'(16'sh8000) : sample_t'(16'sh0000);
            default:     return sample_t'($urandom);
        endcase
    endfunction

    task automatic send_block(int len, sample_style_t style);
        for (int i = 0; i < len; i++)
            send_item(pick_sample(style), i == len - 1);
    endtask

    // Stop offering and wait until every queued report has come back
    task automatic drain();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (pending_reports.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Receiver: long hold-off first, else random or no stalls
    always @(negedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            result_stall <= 1'b1;
            rx_hold_cycles = rx_hold_cycles - 1;
        end
        else if (rx_idle)
            result_stall <= ($urandom_range(99) < IDLE_PCT);
        else
            result_stall <= 1'b0;
    end

    // Compare each taken result item against the oldest pending report
    always @(posedge clk)
    begin : check_results
        peak_report_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("unexpected result item: peak=%0d window_seen=%0b", peak, window_seen);
                error_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (peak !== want.peak)
                begin
                    $error("peak: expected %0d, actual %0d", want.peak, peak);
                    error_count++;
                end
                if (window_seen !== want.window_seen)
                begin
                    $error("window_seen: expected %0b, actual %0b",
                           want.window_seen, window_seen);
                    error_count++;
                end
            end
        end
    end

    // Full-scale windows, including the largest possible magnitude
    task automatic test_full_scale();
        sample_t worst [TAPS];
        worst = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                  16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
        for (int i = 0; i < TAPS; i++)
            send_item(worst[i], i == TAPS - 1);
        for (int i = 0; i < TAPS + 1; i++)
            send_item(16'sh8000, i == TAPS);
    endtask

    // Blocks that end before a window fills, right after full blocks
    task automatic test_short_blocks();
        send_item(16'sh7fff, 1'b1);
        for (int i = 0; i < TAPS - 1; i++)
            send_item((i % 2) ? 16'sh7fff : 16'sh8000, i == TAPS - 2);
    endtask

    // Receiver holds off while the sender keeps closing blocks
    task automatic test_receiver_hold();
        rx_hold_cycles = 300;
        for (int b = 0; b < 30; b++)
            send_block($urandom_range(1, 3), STYLE_FULL);
    endtask

    // Back-to-back traffic on both sides
    task automatic test_no_idle();
        int sent;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        sent = 0;
        while (sent < 300)
        begin
            automatic int len = $urandom_range(1, 24);
            send_block(len, STYLE_FULL);
            sent += len;
        end
        drain();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Random block lengths and sample styles with idling on both sides
    task automatic test_random_blocks(int item_budget);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < item_budget)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                len = $urandom_range(TAPS, 40);
            else if (pick < 92)
                len = $urandom_range(1, TAPS - 1);
            else
                len = $urandom_range(41, 200);
            send_block(len, sample_style_t'($urandom_range(2)));
            sent += len;
        end
    endtask

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("[interpolated_peak_detector_unit] ERROR");
        $finish;
    end

    initial
    begin
        clear_model();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_full_scale();
        test_short_blocks();
        drain();
        test_receiver_hold();
        drain();
        test_no_idle();
        test_random_blocks(1370);

        drain();
        if (error_count == 0)
            $display("[interpolated_peak_detector_unit] OK");
        else
            $display("[interpolated_peak_detector_unit] ERROR");
        $finish;
    end

endmodule

### interpolated_peak_detector_unit.f
sv/ipd_pkg.sv
sv/ipd_interp.sv
sv/interpolated_peak_detector_unit.sv
bench/tb_interpolated_peak_detector_unit.sv
